### design/sti_pkg.sv
package sti_pkg;

	localparam int COORD_WIDTH = 32;

	// difference of two coordinates
	localparam int DW = COORD_WIDTH + 1;
	// cross product component
	localparam int PW = 2 * DW + 1;
	// split of a cross component for the dot-product multipliers
	localparam int LO_W = (PW + 1) / 2;
	localparam int HI_W = PW - LO_W;
	localparam int PLO_W = DW + LO_W + 1;
	localparam int PHI_W = DW + HI_W;
	// determinant and numerators, with headroom for sums and negation
	localparam int NW = DW + PW + 2;

	localparam int DEPS_W = 32;
	localparam int TEPS_W = 16;
	localparam int T_SH = 16;

	// split of |det| for the t margin product
	localparam int AH = (NW + 1) / 2;
	localparam int TLO_W = AH + TEPS_W;
	localparam int THI_W = NW - AH + TEPS_W;
	localparam int TW = NW + T_SH + 1;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = (COORD_WIDTH > DEPS_W) ? COORD_WIDTH : DEPS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_START_Z = 3'd2,
		CFG_DET_EPS = 3'd3,
		CFG_T_EPS   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		RSN_HIT      = 3'd0,
		RSN_PARALLEL = 3'd1,
		RSN_U_OUT    = 3'd2,
		RSN_V_OUT    = 3'd3,
		RSN_T_OUT    = 3'd4
	} reason_t;

endpackage

### design/segment_triangle_intersect.sv
// Segment / triangle crossing test, one test per transfer.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//   Index 0..2 segment start x, y, z; 3 det_epsilon; 4 t_epsilon; other
//   indexes are dropped. Write only while the pipeline is empty.
// Input: in_valid/in_stall with the end point and three vertices, one item
//   per cycle while in_stall is low. Output: out_valid/out_stall with hit and reason.
// Pipeline: 11 stages of subtracts, 33x33 cross products, split 33x67 dot
//   products, adder trees and a split 16-bit margin product for the t window.
// Throughput: one item per cycle while out_stall stays low.
// When the receiver stalls a valid result, every stage holds and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
// Reset: all valid bits clear, start point returns to zero, det_epsilon and
//   t_epsilon return to one.
module segment_triangle_intersect (
	input  logic clk,
	input  logic arst_n,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sti_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [sti_pkg::CFG_DATA_W-1:0]         cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] end_x,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] end_y,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] end_z,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert0_x,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert0_y,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert0_z,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert1_x,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert1_y,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert1_z,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert2_x,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert2_y,
	input  logic signed [sti_pkg::COORD_WIDTH-1:0] vert2_z,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   hit,
	output logic [2:0]                             reason
);

	localparam int CW = sti_pkg::COORD_WIDTH;
	localparam int DW = sti_pkg::DW;
	localparam int PW = sti_pkg::PW;
	localparam int NW = sti_pkg::NW;
	localparam int TW = sti_pkg::TW;
	localparam int LO_W = sti_pkg::LO_W;
	localparam int AH = sti_pkg::AH;

	// configuration registers
	logic signed [CW-1:0]              start_q [3];
	logic [sti_pkg::DEPS_W-1:0]        det_eps_q;
	logic [sti_pkg::TEPS_W-1:0]        t_eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q[0] <= '0;
			start_q[1] <= '0;
			start_q[2] <= '0;
			det_eps_q <= sti_pkg::DEPS_W'(1);
			t_eps_q <= sti_pkg::TEPS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (sti_pkg::cfg_idx_t'(cfg_index))
				sti_pkg::CFG_START_X: start_q[0] <= cfg_data[CW-1:0];
				sti_pkg::CFG_START_Y: start_q[1] <= cfg_data[CW-1:0];
				sti_pkg::CFG_START_Z: start_q[2] <= cfg_data[CW-1:0];
				sti_pkg::CFG_DET_EPS: det_eps_q <= cfg_data[sti_pkg::DEPS_W-1:0];
				sti_pkg::CFG_T_EPS:   t_eps_q <= cfg_data[sti_pkg::TEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a finished result is held
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			v_s10 <= v_s9;
			out_valid_q <= v_s10;
		end
	end
	assign out_valid = out_valid_q;

	// s1: edge vectors
	logic signed [CW-1:0] e_in [3], v0_in [3], v1_in [3], v2_in [3];
	assign e_in  = '{end_x, end_y, end_z};
	assign v0_in = '{vert0_x, vert0_y, vert0_z};
	assign v1_in = '{vert1_x, vert1_y, vert1_z};
	assign v2_in = '{vert2_x, vert2_y, vert2_z};

	logic signed [DW-1:0] d_s1 [3], e1_s1 [3], e2_s1 [3], tv_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DW'(e_in[i]) - DW'(start_q[i]);
				e1_s1[i] <= DW'(v1_in[i]) - DW'(v0_in[i]);
				e2_s1[i] <= DW'(v2_in[i]) - DW'(v0_in[i]);
				tv_s1[i] <= DW'(start_q[i]) - DW'(v0_in[i]);
			end
		end
	end

	// s2: cross product terms, P = D x E2, Q = T x E1
	logic signed [2*DW-1:0] pa_s2 [3], pb_s2 [3], qa_s2 [3], qb_s2 [3];
	logic signed [DW-1:0] d_s2 [3], e1_s2 [3], e2_s2 [3], tv_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2[0] <= d_s1[1] * e2_s1[2];  pb_s2[0] <= d_s1[2] * e2_s1[1];
			pa_s2[1] <= d_s1[2] * e2_s1[0];  pb_s2[1] <= d_s1[0] * e2_s1[2];
			pa_s2[2] <= d_s1[0] * e2_s1[1];  pb_s2[2] <= d_s1[1] * e2_s1[0];
			qa_s2[0] <= tv_s1[1] * e1_s1[2]; qb_s2[0] <= tv_s1[2] * e1_s1[1];
			qa_s2[1] <= tv_s1[2] * e1_s1[0]; qb_s2[1] <= tv_s1[0] * e1_s1[2];
			qa_s2[2] <= tv_s1[0] * e1_s1[1]; qb_s2[2] <= tv_s1[1] * e1_s1[0];
			d_s2 <= d_s1; e1_s2 <= e1_s1; e2_s2 <= e2_s1; tv_s2 <= tv_s1;
		end
	end

	// s3: cross products
	logic signed [PW-1:0] p_s3 [3], q_s3 [3];
	logic signed [DW-1:0] d_s3 [3], e1_s3 [3], e2_s3 [3], tv_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= PW'(pa_s2[i]) - PW'(pb_s2[i]);
				q_s3[i] <= PW'(qa_s2[i]) - PW'(qb_s2[i]);
			end
			d_s3 <= d_s2; e1_s3 <= e1_s2; e2_s3 <= e2_s2; tv_s3 <= tv_s2;
		end
	end

	// s4: dot product partials; 0 det = E1.P, 1 u = T.P, 2 v = D.Q, 3 t = E2.Q
	logic signed [DW-1:0] opa [4][3];
	logic signed [PW-1:0] opb [4][3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opa[0][i] = e1_s3[i]; opb[0][i] = p_s3[i];
			opa[1][i] = tv_s3[i]; opb[1][i] = p_s3[i];
			opa[2][i] = d_s3[i];  opb[2][i] = q_s3[i];
			opa[3][i] = e2_s3[i]; opb[3][i] = q_s3[i];
		end
	end

	logic signed [sti_pkg::PLO_W-1:0] lo_s4 [4][3];
	logic signed [sti_pkg::PHI_W-1:0] hi_s4 [4][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					lo_s4[k][i] <= opa[k][i] * $signed({1'b0, opb[k][i][LO_W-1:0]});
					hi_s4[k][i] <= opa[k][i] * $signed(opb[k][i][PW-1:LO_W]);
				end
			end
		end
	end

	// s5: rejoin split products
	logic signed [NW-1:0] prod_s5 [4][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s5[k][i] <= (NW'(hi_s4[k][i]) <<< LO_W) + NW'(lo_s4[k][i]);
				end
			end
		end
	end

	// s6: dot sums
	logic signed [NW-1:0] dot_s6 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				dot_s6[k] <= prod_s5[k][0] + prod_s5[k][1] + prod_s5[k][2];
			end
		end
	end

	// s7: fold the sign of det into the numerators
	logic signed [NW-1:0] adet_s7, un_s7, vn_s7, tn_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dot_s6[0][NW-1]) begin
				adet_s7 <= -dot_s6[0];
				un_s7 <= -dot_s6[1];
				vn_s7 <= -dot_s6[2];
				tn_s7 <= -dot_s6[3];
			end else begin
				adet_s7 <= dot_s6[0];
				un_s7 <= dot_s6[1];
				vn_s7 <= dot_s6[2];
				tn_s7 <= dot_s6[3];
			end
		end
	end

	// s8: parallel, u and v tests; margin product partials
	sti_pkg::reason_t rsn_s8, rsn_s9, rsn_s10;
	logic [sti_pkg::TLO_W-1:0] tl_s8;
	logic [sti_pkg::THI_W-1:0] th_s8;
	logic signed [NW-1:0] adet_s8, tn_s8, adet_s9, tn_s9, tn_s10;
	logic signed [NW-1:0] uv_sum;
	assign uv_sum = un_s7 + vn_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (adet_s7 == '0 || adet_s7 < $signed({1'b0, NW'(det_eps_q)}))
				rsn_s8 <= sti_pkg::RSN_PARALLEL;
			else if (un_s7 < 0 || un_s7 > adet_s7)
				rsn_s8 <= sti_pkg::RSN_U_OUT;
			else if (vn_s7 < 0 || uv_sum > adet_s7)
				rsn_s8 <= sti_pkg::RSN_V_OUT;
			else
				rsn_s8 <= sti_pkg::RSN_HIT;
			tl_s8 <= sti_pkg::TLO_W'(adet_s7[AH-1:0]) * sti_pkg::TLO_W'(t_eps_q);
			th_s8 <= sti_pkg::THI_W'(adet_s7[NW-1:AH]) * sti_pkg::THI_W'(t_eps_q);
			adet_s8 <= adet_s7;
			tn_s8 <= tn_s7;
		end
	end

	// s9: low bound of the t window, teps * |det|
	logic [TW-1:0] lo_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s9 <= (TW'(th_s8) << AH) + TW'(tl_s8);
			rsn_s9 <= rsn_s8;
			adet_s9 <= adet_s8;
			tn_s9 <= tn_s8;
		end
	end

	// s10: lower compare and upper bound
	logic signed [TW-1:0] tsc_s9, tsc_s10;
	logic signed [TW-1:0] hi_s10;
	logic gt_s10;
	assign tsc_s9 = TW'(tn_s9) <<< sti_pkg::T_SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			gt_s10 <= tsc_s9 > $signed(lo_s9);
			hi_s10 <= (TW'(adet_s9) <<< sti_pkg::T_SH) - $signed(lo_s9);
			rsn_s10 <= rsn_s9;
			tn_s10 <= tn_s9;
		end
	end
	assign tsc_s10 = TW'(tn_s10) <<< sti_pkg::T_SH;

	// s11: output register
	sti_pkg::reason_t reason_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rsn_s10 != sti_pkg::RSN_HIT)
				reason_q <= rsn_s10;
			else if (!(gt_s10 && tsc_s10 < hi_s10))
				reason_q <= sti_pkg::RSN_T_OUT;
			else
				reason_q <= sti_pkg::RSN_HIT;
		end
	end

	assign reason = reason_q;
	assign hit = (reason_q == sti_pkg::RSN_HIT);

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (reason == sti_pkg::RSN_HIT)))
		else $error("hit flag disagrees with reason code");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted transfer did not enter the pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(v_s5) && $stable(v_s10)))
		else $error("pipeline moved while the output was held");

endmodule

### tb/tb_segment_triangle_intersect.sv
module tb_segment_triangle_intersect;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = sti_pkg::COORD_WIDTH;

	typedef logic signed [255:0] wide_t;
	// field order: end xyz, vertex 0 xyz, vertex 1 xyz, vertex 2 xyz
	typedef logic [11:0][CW-1:0] tri_seg_t;
	typedef struct packed {
		logic             hit;
		sti_pkg::reason_t rsn;
	} verdict_t;
	typedef struct packed {
		logic             typed;
		sti_pkg::reason_t rsn;
		tri_seg_t         c;
	} dir_row_t;

	localparam int N_DIR = 11;
	localparam int N_PHASE = 6;
	localparam int LAT = 11;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [sti_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sti_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	tri_seg_t item;
	logic out_valid;
	logic out_stall;
	logic hit;
	logic [2:0] reason;

	// local copy of the configuration
	logic [CW-1:0] start_reg [3];
	logic [31:0] det_eps;
	logic [15:0] t_eps;

	verdict_t verdict_q [$];
	int errors;
	int results_seen;

	segment_triangle_intersect u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.end_x    (item[0]),
		.end_y    (item[1]),
		.end_z    (item[2]),
		.vert0_x  (item[3]),
		.vert0_y  (item[4]),
		.vert0_z  (item[5]),
		.vert1_x  (item[6]),
		.vert1_y  (item[7]),
		.vert1_z  (item[8]),
		.vert2_x  (item[9]),
		.vert2_y  (item[10]),
		.vert2_z  (item[11]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.reason   (reason)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL segment_triangle_intersect");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic wide_t widen(input logic [CW-1:0] v);
		wide_t w;
		w = wide_t'($signed(v));
		return w;
	endfunction

	// exact Moller-Trumbore, all comparisons scaled by |det|
	function automatic sti_pkg::reason_t crossing_reason(input tri_seg_t it);
		wide_t s [3], v0 [3], d [3], e1 [3], e2 [3], tv [3], p [3], q [3];
		wide_t det, adet, un, vn, tn, lo, hi, deps_w, teps_w, one;
		logic neg;
		for (int i = 0; i < 3; i++) begin
			s[i]  = widen(start_reg[i]);
			v0[i] = widen(it[3 + i]);
			d[i]  = widen(it[i]) - s[i];
			e1[i] = widen(it[6 + i]) - v0[i];
			e2[i] = widen(it[9 + i]) - v0[i];
			tv[i] = s[i] - v0[i];
		end
		p[0] = d[1] * e2[2] - d[2] * e2[1];
		p[1] = d[2] * e2[0] - d[0] * e2[2];
		p[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = tv[1] * e1[2] - tv[2] * e1[1];
		q[1] = tv[2] * e1[0] - tv[0] * e1[2];
		q[2] = tv[0] * e1[1] - tv[1] * e1[0];
		det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
		neg = det < 0;
		adet = neg ? -det : det;
		deps_w = '0;
		deps_w[31:0] = det_eps;
		teps_w = '0;
		teps_w[15:0] = t_eps;
		one = wide_t'(65536);
		if (det == 0 || adet < deps_w)
			return sti_pkg::RSN_PARALLEL;
		un = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
		if (neg) un = -un;
		if (un < 0 || un > adet)
			return sti_pkg::RSN_U_OUT;
		vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
		if (neg) vn = -vn;
		if (vn < 0 || un + vn > adet)
			return sti_pkg::RSN_V_OUT;
		tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
		if (neg) tn = -tn;
		lo = teps_w * adet;
		hi = (one - teps_w) * adet;
		if (!(tn * one > lo && tn * one < hi))
			return sti_pkg::RSN_T_OUT;
		return sti_pkg::RSN_HIT;
	endfunction

	function automatic tri_seg_t mk(input int ex, ey, ez, ax, ay, az, bx, by, bz,
			cx, cy, cz);
		tri_seg_t r;
		r = {cz, cy, cx, bz, by, bx, az, ay, ax, ez, ey, ex};
		return r;
	endfunction

	function automatic longint offs(input int r);
		return longint'($urandom_range(0, 2 * r)) - r;
	endfunction

	// mostly segments aimed through a random triangle, the rest noise
	function automatic tri_seg_t random_item();
		tri_seg_t r;
		longint s [3], v0 [3], e1 [3], e2 [3], pt;
		int mode, a, b, k;
		mode = $urandom_range(0, 19);
		for (int i = 0; i < 3; i++)
			s[i] = longint'($signed(start_reg[i]));
		if (mode < 4) begin
			for (int i = 0; i < 12; i++)
				r[i] = $urandom;
		end else if (mode < 7) begin
			for (int i = 0; i < 12; i++)
				r[i] = CW'(s[i % 3] + offs(4096));
		end else begin
			a = $urandom_range(0, 256);
			b = $urandom_range(0, 256 - a);
			k = $urandom_range(4, 40);
			for (int i = 0; i < 3; i++) begin
				v0[i] = s[i] + offs(1 << 18);
				e1[i] = offs(1 << 18);
				e2[i] = offs(1 << 18);
				pt = v0[i] + (a * e1[i] + b * e2[i]) / 256;
				r[i] = CW'(s[i] + (pt - s[i]) * 16 / k);
				r[3 + i] = CW'(v0[i]);
				r[6 + i] = CW'(v0[i] + e1[i]);
				r[9 + i] = CW'(v0[i] + e2[i]);
			end
			if (mode == 19) begin
				// degenerate triangle or zero-length segment
				if ($urandom_range(0, 1))
					r[11:9] = r[5:3];
				else
					for (int i = 0; i < 3; i++)
						r[i] = start_reg[i];
			end
		end
		return r;
	endfunction

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [sti_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sti_pkg::CFG_START_X, sti_pkg::CFG_START_Y, sti_pkg::CFG_START_Z:
				start_reg[idx] = v;
			sti_pkg::CFG_DET_EPS: det_eps = v;
			sti_pkg::CFG_T_EPS: t_eps = v[15:0];
			default: ;
		endcase
	endtask

	task automatic send(input tri_seg_t it, input logic typed,
			input sti_pkg::reason_t rsn);
		int gap;
		verdict_t vd;
		gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		vd.rsn = typed ? rsn : crossing_reason(it);
		vd.hit = (vd.rsn == sti_pkg::RSN_HIT);
		verdict_q = {verdict_q, vd};
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off to back the pipe up
	initial begin
		int gap;
		verdict_t vd;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
			if (results_seen == 200) gap = 80;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_seen++;
			if (verdict_q.size() == 0) begin
				report($sformatf("unexpected result hit=%0b reason=%0d", hit, reason));
			end else begin
				vd = verdict_q.pop_front();
				if (hit !== vd.hit)
					report($sformatf("hit %0b, want %0b", hit, vd.hit));
				if (reason !== vd.rsn)
					report($sformatf("reason %0d, want %0d", reason, vd.rsn));
			end
		end
	end

	initial begin
		dir_row_t rows [N_DIR];
		int n_rand;
		errors = 0;
		results_seen = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		item = '0;
		start_reg = '{default: '0};
		det_eps = 32'd1;
		t_eps = 16'd1;

		rows[0]  = '{1'b1, sti_pkg::RSN_PARALLEL, '0};
		rows[1]  = '{1'b1, sti_pkg::RSN_PARALLEL, {12{32'h7fffffff}}};
		rows[2]  = '{1'b1, sti_pkg::RSN_PARALLEL, {12{32'h80000000}}};
		rows[3]  = '{1'b1, sti_pkg::RSN_HIT, mk(0, 0, 2048, -1024, -1024, 1024,
			3072, -1024, 1024, -1024, 3072, 1024)};
		// zero-length segment
		rows[4]  = '{1'b1, sti_pkg::RSN_PARALLEL, mk(0, 0, 0, -1024, -1024, 1024,
			3072, -1024, 1024, -1024, 3072, 1024)};
		rows[5]  = '{1'b0, sti_pkg::RSN_HIT, mk(0, 0, 2048, 1024, -1024, 1024,
			5120, -1024, 1024, 1024, 3072, 1024)};
		rows[6]  = '{1'b0, sti_pkg::RSN_HIT, mk(0, 0, 2048, -1024, 1024, 1024,
			3072, 1024, 1024, -1024, 5120, 1024)};
		rows[7]  = '{1'b0, sti_pkg::RSN_HIT, mk(0, 0, 512, -1024, -1024, 1024,
			3072, -1024, 1024, -1024, 3072, 1024)};
		rows[8]  = '{1'b0, sti_pkg::RSN_HIT, mk(0, 0, -2048, -1024, -1024, 1024,
			3072, -1024, 1024, -1024, 3072, 1024)};
		// crossing exactly at a vertex
		rows[9]  = '{1'b0, sti_pkg::RSN_HIT, mk(0, 0, 2048, 0, 0, 1024,
			4096, 0, 1024, 0, 4096, 1024)};
		rows[10] = '{1'b0, sti_pkg::RSN_HIT, mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			0, 32'h80000000, 32'h80000000)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				1: begin
					write_reg(sti_pkg::CFG_START_X, 32'd1000);
					write_reg(sti_pkg::CFG_START_Y, -32'sd2000);
					write_reg(sti_pkg::CFG_START_Z, 32'd3000);
					write_reg(sti_pkg::CFG_DET_EPS, 32'd0);
					write_reg(sti_pkg::CFG_T_EPS, 32'h1234_0000);
					// indexes past the last register are dropped
					for (int i = sti_pkg::CFG_T_EPS + 1; i < (1 << sti_pkg::CFG_IDX_W); i++)
						write_reg(sti_pkg::CFG_IDX_W'(i), $urandom);
				end
				2: begin
					write_reg(sti_pkg::CFG_START_X, 32'h80000000);
					write_reg(sti_pkg::CFG_START_Y, 32'h7fffffff);
					write_reg(sti_pkg::CFG_START_Z, 32'h80000000);
					write_reg(sti_pkg::CFG_DET_EPS, 32'hffffffff);
					write_reg(sti_pkg::CFG_T_EPS, 32'h0000ffff);
				end
				3: begin
					write_reg(sti_pkg::CFG_START_X, 32'd12345);
					write_reg(sti_pkg::CFG_START_Y, -32'sd54321);
					write_reg(sti_pkg::CFG_START_Z, 32'd777);
					write_reg(sti_pkg::CFG_DET_EPS, 32'd1 << 20);
					write_reg(sti_pkg::CFG_T_EPS, 32'd32768);
				end
				4: begin
					write_reg(sti_pkg::CFG_START_X, 32'd0);
					write_reg(sti_pkg::CFG_START_Y, 32'd0);
					write_reg(sti_pkg::CFG_START_Z, 32'd0);
					write_reg(sti_pkg::CFG_DET_EPS, 32'd5);
					write_reg(sti_pkg::CFG_T_EPS, 32'd3000);
				end
				5: begin
					write_reg(sti_pkg::CFG_START_X, 32'(offs(1 << 27)));
					write_reg(sti_pkg::CFG_START_Y, 32'(offs(1 << 27)));
					write_reg(sti_pkg::CFG_START_Z, 32'(offs(1 << 27)));
					write_reg(sti_pkg::CFG_DET_EPS, $urandom_range(0, 1 << 16));
					write_reg(sti_pkg::CFG_T_EPS, $urandom_range(0, 2000));
				end
				default: ;
			endcase
			cfg_valid <= 1'b0;
			if (ph == 0)
				foreach (rows[i])
					send(rows[i].c, rows[i].typed, rows[i].rsn);
			n_rand = (ph == 0) ? 150 : 160;
			for (int i = 0; i < n_rand; i++)
				send(random_item(), 1'b0, sti_pkg::RSN_HIT);
			drain();
		end

		if (errors == 0)
			$display("PASS segment_triangle_intersect");
		else
			$display("FAIL segment_triangle_intersect");
		$finish;
	end

endmodule
